// ----- src/jccs_pkg.sv -----
// ----------------------------------------------------------------------------
// jccs_pkg
// Shared types, character codes and helpers for the JSON5 comment and
// trailing-comma stripper.
// ----------------------------------------------------------------------------
package jccs_pkg;

	localparam int WS_HOLD_DEPTH = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QAW           = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;

	// one operation handed from the front part to the back part
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       emit_comma;
		logic       flush;
		logic       emit_byte;
		logic       hold;
		logic       ovf;
		logic       run_last;
		logic       text_done;
	} jccs_op_t;

	// effect of one byte on the trailing-comma logic
	typedef struct packed {
		logic emit_comma;
		logic flush;
		logic emit_byte;
		logic hold;
		logic ovf;
		logic pend;
		logic clr;
	} comma_res_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	function automatic comma_res_t comma_step(input logic pend, input logic full,
			input logic [7:0] b);
		comma_res_t r;
		r      = '0;
		r.pend = pend;
		if (pend) begin
			if ((b == CH_RBRACKET) || (b == CH_RBRACE)) begin
				r.flush     = 1'b1;
				r.emit_byte = 1'b1;
				r.pend      = 1'b0;
			end else if (is_ws(b)) begin
				if (!full) begin
					r.hold = 1'b1;
				end else begin
					r.ovf        = 1'b1;
					r.emit_comma = 1'b1;
					r.flush      = 1'b1;
					r.emit_byte  = 1'b1;
					r.pend       = 1'b0;
				end
			end else if (b == CH_COMMA) begin
				r.emit_comma = 1'b1;
				r.flush      = 1'b1;
			end else begin
				r.emit_comma = 1'b1;
				r.flush      = 1'b1;
				r.emit_byte  = 1'b1;
				r.pend       = 1'b0;
			end
		end else if (b == CH_COMMA) begin
			r.pend = 1'b1;
			r.clr  = 1'b1;
		end else begin
			r.emit_byte = 1'b1;
		end
		return r;
	endfunction

	function automatic jccs_op_t make_op(input comma_res_t r, input logic [7:0] b);
		jccs_op_t op;
		op            = '0;
		op.data       = b;
		op.has_byte   = 1'b1;
		op.emit_comma = r.emit_comma;
		op.flush      = r.flush;
		op.emit_byte  = r.emit_byte;
		op.hold       = r.hold;
		return op;
	endfunction

endpackage

// ----- src/jccs_queue.sv -----
// ----------------------------------------------------------------------------
// jccs_queue
// Small FIFO of operations between the front and back parts.
// ----------------------------------------------------------------------------
module jccs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jccs_pkg::jccs_op_t  op_in,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output jccs_pkg::jccs_op_t  op_out
);

	jccs_pkg::jccs_op_t slot_q [jccs_pkg::QUEUE_DEPTH];
	logic [jccs_pkg::QAW-1:0] wptr_q;
	logic [jccs_pkg::QAW-1:0] rptr_q;
	logic [jccs_pkg::QAW:0]   cnt_q;

	assign full   = (cnt_q == (jccs_pkg::QAW+1)'(jccs_pkg::QUEUE_DEPTH));
	assign valid  = (cnt_q != '0);
	assign op_out = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= op_in;
		end
	end

endmodule

// ----- src/jccs_front.sv -----
// ----------------------------------------------------------------------------
// jccs_front
// Comment lexer and trailing-comma classifier; splits each input word into
// queue operations.
// ----------------------------------------------------------------------------
module jccs_front #(
	parameter int DEPTH = jccs_pkg::WS_HOLD_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                q_push,
	output jccs_pkg::jccs_op_t  q_op
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int NSLOT = 5;

	typedef enum logic [2:0] {
		M_NORMAL,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_BLOCK_STAR
	} lex_mode_t;

	lex_mode_t       mode_q;
	logic            instr_q;
	logic [7:0]      prev_q;
	logic            pend_q;
	logic [CW-1:0]   cnt_q;
	logic [2:0]      phase_q;

	lex_mode_t       mode_n;
	logic            instr_n;
	logic            c1_en, c2_en, c3_en, normal_en;
	jccs_pkg::comma_res_t r1, r2, r3;
	logic            p1, p2, p3;
	logic [CW-1:0]   n1, n2;
	jccs_pkg::jccs_op_t slot_op [NSLOT];
	logic [NSLOT-1:0] slot_v;
	logic [NSLOT-1:0] slot_prod;
	logic            later, step_ovf, found, more;
	logic [2:0]      sel;

	function automatic logic [CW-1:0] next_cnt(input jccs_pkg::comma_res_t r,
			input logic [CW-1:0] n);
		if (r.hold) begin
			return n + CW'(1);
		end else if (r.flush || r.clr) begin
			return '0;
		end
		return n;
	endfunction

	always_comb begin
		mode_n    = mode_q;
		instr_n   = instr_q;
		c1_en     = 1'b0;
		c2_en     = 1'b0;
		normal_en = 1'b0;
		unique case (mode_q)
			M_LINE: begin
				if (s_tdata == jccs_pkg::CH_LF) begin
					mode_n    = M_NORMAL;
					normal_en = 1'b1;
				end
			end
			M_BLOCK: begin
				if (s_tdata == jccs_pkg::CH_STAR) begin
					mode_n = M_BLOCK_STAR;
				end
			end
			M_BLOCK_STAR: begin
				if (s_tdata == jccs_pkg::CH_SLASH) begin
					mode_n = M_NORMAL;
				end else if (s_tdata != jccs_pkg::CH_STAR) begin
					mode_n = M_BLOCK;
				end
			end
			M_SLASH: begin
				if (s_tdata == jccs_pkg::CH_SLASH) begin
					mode_n = M_LINE;
				end else if (s_tdata == jccs_pkg::CH_STAR) begin
					mode_n = M_BLOCK;
				end else begin
					c1_en     = 1'b1;
					mode_n    = M_NORMAL;
					normal_en = 1'b1;
				end
			end
			default: begin
				mode_n    = M_NORMAL;
				normal_en = 1'b1;
			end
		endcase
		if (normal_en) begin
			if ((s_tdata == jccs_pkg::CH_QUOTE) && (prev_q != jccs_pkg::CH_BSLASH)) begin
				instr_n = ~instr_q;
				c2_en   = 1'b1;
			end else if (instr_q) begin
				c2_en = 1'b1;
			end else if (s_tdata == jccs_pkg::CH_SLASH) begin
				mode_n = M_SLASH;
			end else begin
				c2_en = 1'b1;
			end
		end

		// walk the comma logic through every byte this word releases
		r1 = c1_en ? jccs_pkg::comma_step(pend_q, cnt_q == CW'(DEPTH), jccs_pkg::CH_SLASH)
			: jccs_pkg::comma_res_t'('0);
		p1 = c1_en ? r1.pend : pend_q;
		n1 = c1_en ? next_cnt(r1, cnt_q) : cnt_q;
		r2 = c2_en ? jccs_pkg::comma_step(p1, n1 == CW'(DEPTH), s_tdata)
			: jccs_pkg::comma_res_t'('0);
		p2 = c2_en ? r2.pend : p1;
		n2 = c2_en ? next_cnt(r2, n1) : n1;
		c3_en = s_tlast && (mode_n == M_SLASH);
		r3 = c3_en ? jccs_pkg::comma_step(p2, n2 == CW'(DEPTH), jccs_pkg::CH_SLASH)
			: jccs_pkg::comma_res_t'('0);
		p3 = c3_en ? r3.pend : p2;

		slot_op[0] = jccs_pkg::make_op(r1, jccs_pkg::CH_SLASH);
		slot_op[1] = jccs_pkg::make_op(r2, s_tdata);
		slot_op[2] = jccs_pkg::make_op(r3, jccs_pkg::CH_SLASH);
		slot_op[3] = '0;
		slot_op[3].data       = jccs_pkg::CH_COMMA;
		slot_op[3].has_byte   = 1'b1;
		slot_op[3].emit_comma = 1'b1;
		slot_op[3].flush      = 1'b1;
		slot_op[4] = '0;
		slot_op[4].emit_byte  = 1'b1;

		slot_v[0] = c1_en;
		slot_v[1] = c2_en && (r2.emit_comma || r2.emit_byte || r2.hold);
		slot_v[2] = c3_en;
		slot_v[3] = s_tlast && p3;
		slot_prod[0] = c1_en;
		slot_prod[1] = c2_en && (r2.emit_comma || r2.emit_byte);
		slot_prod[2] = c3_en;
		slot_prod[3] = slot_v[3];
		slot_v[4]    = s_tlast && (slot_prod[3:0] == '0);
		slot_prod[4] = slot_v[4];

		step_ovf = r1.ovf || r2.ovf || r3.ovf;
		later    = 1'b0;
		for (int k = NSLOT - 1; k >= 0; k--) begin
			slot_op[k].ovf       = step_ovf;
			slot_op[k].run_last  = slot_prod[k] && !later;
			slot_op[k].text_done = slot_prod[k] && !later && s_tlast;
			later                = later || slot_prod[k];
		end

		found = 1'b0;
		more  = 1'b0;
		sel   = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (slot_v[k] && (3'(k) >= phase_q)) begin
				if (!found) begin
					sel   = 3'(k);
					found = 1'b1;
				end else begin
					more = 1'b1;
				end
			end
		end
	end

	assign q_op     = slot_op[sel];
	assign q_push   = s_tvalid && found && !q_full;
	assign s_tready = !found || (!q_full && !more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			instr_q <= 1'b0;
			prev_q  <= '0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (q_push && more) begin
			phase_q <= sel + 3'd1;
		end else if (s_tvalid && s_tready) begin
			phase_q <= '0;
			if (s_tlast) begin
				mode_q  <= M_NORMAL;
				instr_q <= 1'b0;
				prev_q  <= '0;
				pend_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				mode_q  <= mode_n;
				instr_q <= instr_n;
				prev_q  <= s_tdata;
				pend_q  <= p2;
				cnt_q   <= n2;
			end
		end
	end

endmodule

// ----- src/jccs_back.sv -----
// ----------------------------------------------------------------------------
// jccs_back
// Executes queued operations: holds whitespace after a pending comma and
// streams commas, held bytes and plain bytes out through a registered port.
// ----------------------------------------------------------------------------
module jccs_back #(
	parameter int DEPTH = jccs_pkg::WS_HOLD_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  jccs_pkg::jccs_op_t  q_op,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // out_byte
	output logic [2:0]          m_tuser,   // has_byte, text_done, ws_overflow
	output logic                m_tlast    // run_last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HELD,
		ST_BYTE
	} back_state_t;

	back_state_t        state_q, state_d;
	jccs_pkg::jccs_op_t cur_q;
	logic [CW-1:0]      hcnt_q, hcnt_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [7:0]         ws_mem [DEPTH];
	logic [7:0]         rd_q;
	logic               m_tvalid_q;
	logic [7:0]         m_tdata_q;
	logic [2:0]         m_tuser_q;
	logic               m_tlast_q;

	logic       ld_ok, ld, wr, cur_ld;
	logic [7:0] o_data;
	logic       o_has, o_last, o_done, o_ovf;

	always_comb begin
		ld_ok   = !m_tvalid_q || m_tready;
		q_pop   = 1'b0;
		wr      = 1'b0;
		ld      = 1'b0;
		cur_ld  = 1'b0;
		o_data  = '0;
		o_has   = 1'b1;
		o_last  = 1'b0;
		o_done  = 1'b0;
		o_ovf   = cur_q.ovf;
		state_d = state_q;
		hcnt_d  = hcnt_q;
		idx_d   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_op.hold) begin
						q_pop  = 1'b1;
						wr     = 1'b1;
						hcnt_d = hcnt_q + CW'(1);
					end else if (q_op.emit_comma) begin
						if (ld_ok) begin
							q_pop  = 1'b1;
							cur_ld = 1'b1;
							ld     = 1'b1;
							o_data = jccs_pkg::CH_COMMA;
							o_ovf  = q_op.ovf;
							if (q_op.flush && (hcnt_q != '0)) begin
								state_d = ST_HELD;
							end else if (q_op.emit_byte) begin
								state_d = ST_BYTE;
							end else begin
								o_last = q_op.run_last;
								o_done = q_op.text_done;
							end
						end
					end else if (q_op.flush && (hcnt_q != '0)) begin
						q_pop   = 1'b1;
						cur_ld  = 1'b1;
						state_d = ST_HELD;
					end else if (ld_ok) begin
						q_pop  = 1'b1;
						ld     = 1'b1;
						o_data = q_op.data;
						o_has  = q_op.has_byte;
						o_last = q_op.run_last;
						o_done = q_op.text_done;
						o_ovf  = q_op.ovf;
					end
				end
			end
			ST_HELD: begin
				if (ld_ok) begin
					ld     = 1'b1;
					o_data = rd_q;
					if ((idx_q + CW'(1)) == hcnt_q) begin
						idx_d  = '0;
						hcnt_d = '0;
						if (cur_q.emit_byte) begin
							state_d = ST_BYTE;
						end else begin
							state_d = ST_IDLE;
							o_last  = cur_q.run_last;
							o_done  = cur_q.text_done;
						end
					end else begin
						idx_d = idx_q + CW'(1);
					end
				end
			end
			ST_BYTE: begin
				if (ld_ok) begin
					ld      = 1'b1;
					o_data  = cur_q.data;
					o_has   = cur_q.has_byte;
					o_last  = cur_q.run_last;
					o_done  = cur_q.text_done;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			hcnt_q     <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			hcnt_q  <= hcnt_d;
			idx_q   <= idx_d;
			if (cur_ld) begin
				cur_q <= q_op;
			end
			if (ld) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= o_data;
				m_tuser_q  <= {o_ovf, o_done, o_has};
				m_tlast_q  <= o_last;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// whitespace store: read address tracks the next flush index
	always_ff @(posedge clk) begin
		if (wr) begin
			ws_mem[hcnt_q[AW-1:0]] <= q_op.data;
		end
		rd_q <= ws_mem[idx_d[AW-1:0]];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- src/json5_comment_comma_stripper.sv -----
// ----------------------------------------------------------------------------
// json5_comment_comma_stripper
// Streams JSON5 text in and strict JSON out, one byte per word.
// ----------------------------------------------------------------------------
// Comments outside strings are removed and a comma followed only by
// whitespace and a closing bracket or brace is dropped; up to WS_HOLD_DEPTH
// whitespace bytes after a comma are held, beyond that the comma is kept and
// ws_overflow is set on the words of that input byte. An input byte with
// s_tlast set flushes everything and ends with a word carrying text_done; if
// it releases nothing, one empty word (has_byte low) marks the end. The front
// part pushes one queue entry per cycle while the queue is not full; a byte
// that also releases a held slash, or ends the text, can need two entries and
// holds the input until both are pushed. The back part sends one output word
// per cycle from a four-entry queue while the output is ready; a flush sends
// the comma if kept, then the held whitespace from the local store one byte
// per cycle, then the byte that ended it if any, entering the held state first
// without a word when it starts with held bytes. Otherwise the input stalls
// only while the queue is full, behind such a flush or a stalled output.
module json5_comment_comma_stripper #(
	parameter int WS_HOLD_DEPTH = jccs_pkg::WS_HOLD_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [2:0] m_tuser,   // has_byte, text_done, ws_overflow
	output logic       m_tlast    // run_last
);

	logic               q_push, q_full, q_pop, q_valid;
	jccs_pkg::jccs_op_t q_in, q_out;

	jccs_front #(
		.DEPTH(WS_HOLD_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_op    (q_in)
	);

	jccs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.op_in (q_in),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.op_out(q_out)
	);

	jccs_back #(
		.DEPTH(WS_HOLD_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (q_out),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON5 comment and trailing-comma stripper.
// ----------------------------------------------------------------------------
// Text is streamed in one byte per word in bursts with random gaps, while the
// output side stalls on its own pattern. A model of the lexer and of the
// trailing-comma filter runs on every accepted byte and queues the words it
// should cause; each output word is checked against the oldest one. Directed
// texts cover comments, escaped quotes, comma handling, end-of-text flushing
// and whitespace overflow, followed by random well-formed texts and noise.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum logic [2:0] {
		LX_NORMAL,
		LX_SLASH,
		LX_LINE,
		LX_BLOCK,
		LX_BLOCK_STAR
	} lex_mode_e;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       run_last;
		logic       text_done;
		logic       ws_ovf;
	} out_word_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	// stripper model state
	logic       in_str;
	lex_mode_e  lex_mode;
	logic [7:0] last_raw;
	logic       comma_open;
	logic [7:0] held_ws [jccs_pkg::WS_HOLD_DEPTH];
	int         held_n;
	logic       step_ovf;
	out_word_t  step_q[$];
	out_word_t  clean_q[$];

	int         fails     = 0;
	int         tx_count  = 0;
	int         tx_burst  = 0;
	bit         tx_gaps   = 1'b0;
	bit         rx_choppy = 1'b0;
	int         rx_hold   = 0;
	int         rx_run    = 0;
	bit         rx_on     = 1'b0;
	out_word_t  seen_word;
	out_word_t  want_word;
	logic [7:0] text_q[$];

	json5_comment_comma_stripper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void clear_state();
		in_str     = 1'b0;
		lex_mode   = LX_NORMAL;
		last_raw   = 8'h00;
		comma_open = 1'b0;
		held_n     = 0;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == jccs_pkg::CH_SPACE) || (b == jccs_pkg::CH_TAB) ||
			(b == jccs_pkg::CH_LF) || (b == jccs_pkg::CH_CR);
	endfunction

	function automatic void put_char(logic [7:0] b);
		out_word_t w;
		w = '{data: b, has_byte: 1'b1, run_last: 1'b0, text_done: 1'b0, ws_ovf: 1'b0};
		step_q.insert(step_q.size(), w);
	endfunction

	function automatic void add_text(logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void release_held();
		for (int k = 0; k < held_n; k++)
			put_char(held_ws[k]);
		held_n = 0;
	endfunction

	function automatic void strip_trailing_comma(logic [7:0] b);
		if (comma_open) begin
			if ((b == jccs_pkg::CH_RBRACKET) || (b == jccs_pkg::CH_RBRACE)) begin
				release_held();
				comma_open = 1'b0;
				put_char(b);
			end else if (is_space(b)) begin
				if (held_n < jccs_pkg::WS_HOLD_DEPTH) begin
					held_ws[held_n] = b;
					held_n++;
				end else begin
					step_ovf = 1'b1;
					put_char(jccs_pkg::CH_COMMA);
					release_held();
					put_char(b);
					comma_open = 1'b0;
				end
			end else if (b == jccs_pkg::CH_COMMA) begin
				put_char(jccs_pkg::CH_COMMA);
				release_held();
			end else begin
				put_char(jccs_pkg::CH_COMMA);
				release_held();
				comma_open = 1'b0;
				put_char(b);
			end
		end else if (b == jccs_pkg::CH_COMMA) begin
			comma_open = 1'b1;
			held_n     = 0;
		end else begin
			put_char(b);
		end
	endfunction

	function automatic void lex_plain(logic [7:0] b, logic [7:0] prev);
		if ((b == jccs_pkg::CH_QUOTE) && (prev != jccs_pkg::CH_BSLASH)) begin
			in_str = !in_str;
			strip_trailing_comma(b);
		end else if (in_str) begin
			strip_trailing_comma(b);
		end else if (b == jccs_pkg::CH_SLASH) begin
			lex_mode = LX_SLASH;
		end else begin
			strip_trailing_comma(b);
		end
	endfunction

	function automatic void lex_byte(logic [7:0] b);
		logic [7:0] prev;
		prev = last_raw;
		case (lex_mode)
			LX_LINE: begin
				if (b == jccs_pkg::CH_LF) begin
					lex_mode = LX_NORMAL;
					lex_plain(b, prev);
				end
			end
			LX_BLOCK: begin
				if (b == jccs_pkg::CH_STAR)
					lex_mode = LX_BLOCK_STAR;
			end
			LX_BLOCK_STAR: begin
				if (b == jccs_pkg::CH_SLASH)
					lex_mode = LX_NORMAL;
				else if (b != jccs_pkg::CH_STAR)
					lex_mode = LX_BLOCK;
			end
			LX_SLASH: begin
				if (b == jccs_pkg::CH_SLASH) begin
					lex_mode = LX_LINE;
				end else if (b == jccs_pkg::CH_STAR) begin
					lex_mode = LX_BLOCK;
				end else begin
					strip_trailing_comma(jccs_pkg::CH_SLASH);
					lex_mode = LX_NORMAL;
					lex_plain(b, prev);
				end
			end
			default: begin
				lex_mode = LX_NORMAL;
				lex_plain(b, prev);
			end
		endcase
		last_raw = b;
	endfunction

	function automatic void predict_clean_words(logic [7:0] b, logic last);
		out_word_t marker;
		step_q.delete();
		step_ovf = 1'b0;
		lex_byte(b);
		if (last) begin
			if (lex_mode == LX_SLASH)
				strip_trailing_comma(jccs_pkg::CH_SLASH);
			if (comma_open) begin
				put_char(jccs_pkg::CH_COMMA);
				release_held();
			end
			clear_state();
			if (step_q.size() == 0) begin
				marker = '{data: 8'h00, has_byte: 1'b0, run_last: 1'b0,
					text_done: 1'b0, ws_ovf: 1'b0};
				step_q.insert(step_q.size(), marker);
			end
		end
		foreach (step_q[i])
			step_q[i].ws_ovf = step_ovf;
		if (step_q.size() > 0) begin
			step_q[step_q.size()-1].run_last  = 1'b1;
			step_q[step_q.size()-1].text_done = last;
		end
		foreach (step_q[i])
			clean_q.insert(clean_q.size(), step_q[i]);
	endfunction

	function automatic logic [7:0] pick_from(string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// output side: long hold-offs first, then free running or a stall pattern
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (!rx_choppy) begin
				m_tready <= 1'b1;
			end else begin
				if (rx_run == 0) begin
					rx_on  = !rx_on;
					rx_run = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 5);
				end
				rx_run--;
				m_tready <= rx_on;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_word = '{data: m_tdata, has_byte: m_tuser[0], run_last: m_tlast,
				text_done: m_tuser[1], ws_ovf: m_tuser[2]};
			if (clean_q.size() == 0) begin
				fails++;
				if (fails < 40)
					$display("%0t: unexpected word, got byte %02h has %b last %b done %b ovf %b",
						$realtime, seen_word.data, seen_word.has_byte, seen_word.run_last,
						seen_word.text_done, seen_word.ws_ovf);
			end else begin
				want_word = clean_q.pop_front();
				if (seen_word != want_word) begin
					fails++;
					if (fails < 40)
						$display("%0t: mismatch, expected byte %02h has %b last %b done %b ovf %b",
							$realtime, want_word.data, want_word.has_byte, want_word.run_last,
							want_word.text_done, want_word.ws_ovf,
							", got byte %02h has %b last %b done %b ovf %b",
							seen_word.data, seen_word.has_byte, seen_word.run_last,
							seen_word.text_done, seen_word.ws_ovf);
				end
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		if (tx_burst == 0) begin
			if (tx_gaps) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			tx_burst = $urandom_range(1, 12);
		end
		tx_burst--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_clean_words(b, last);
		tx_count++;
	endtask

	task automatic send_text(input string s, input logic closes);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], closes && (i == s.len() - 1));
	endtask

	// hold input until every queued word has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (clean_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_comments();
		tx_gaps   = 1'b1;
		rx_choppy = 1'b0;
		send_text("/x/*/**/a//q\n", 1'b1);
		drain();
	endtask

	task automatic test_strings();
		rx_choppy = 1'b1;
		send_text("\"\\\"/*,]\"", 1'b1);
		drain();
	endtask

	task automatic test_commas();
		send_word(8'hFF, 1'b0);
		send_text(",, \t]", 1'b0);
		send_word(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_text_end();
		tx_gaps = 1'b0;
		send_text("/", 1'b1);
		send_text("//", 1'b1);
		send_text(", ", 1'b1);
		send_text("/*", 1'b1);
		drain();
	endtask

	task automatic test_ws_overflow();
		tx_gaps   = 1'b1;
		rx_choppy = 1'b1;
		send_word(jccs_pkg::CH_COMMA, 1'b0);
		repeat (jccs_pkg::WS_HOLD_DEPTH + 1) send_word(pick_from(" \t\n\r"), 1'b0);
		send_word(jccs_pkg::CH_RBRACKET, 1'b0);
		send_word(jccs_pkg::CH_COMMA, 1'b0);
		repeat (jccs_pkg::WS_HOLD_DEPTH) send_word(pick_from(" \t\n\r"), 1'b0);
		send_word(jccs_pkg::CH_RBRACE, 1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		tx_gaps   = 1'b0;
		rx_choppy = 1'b0;
		rx_hold   = 300;
		send_word(8'h5B, 1'b0);
		repeat (40) send_word(pick_from("a1,: \"x/"), 1'b0);
		send_word(jccs_pkg::CH_RBRACKET, 1'b1);
		drain();
	endtask

	task automatic test_random();
		int n_tok;
		int nws;
		int cut;
		while (tx_count < 470) begin
			text_q.delete();
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_choppy = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 20)) add_text(8'($urandom_range(0, 255)));
			end else begin
				n_tok = $urandom_range(1, 10);
				repeat (n_tok) begin
					case ($urandom_range(0, 9))
						0, 1: repeat ($urandom_range(1, 4))
							add_text(pick_from("abz09:{[tfn-."));
						2: begin
							add_text(jccs_pkg::CH_QUOTE);
							repeat ($urandom_range(0, 6)) begin
								if ($urandom_range(0, 3) == 0) begin
									add_text(jccs_pkg::CH_BSLASH);
									add_text(jccs_pkg::CH_QUOTE);
								end else begin
									add_text(pick_from("ab ,]}/*\\"));
								end
							end
							add_text(jccs_pkg::CH_QUOTE);
						end
						3: begin
							add_text(jccs_pkg::CH_SLASH);
							add_text(jccs_pkg::CH_SLASH);
							repeat ($urandom_range(0, 5)) add_text(pick_from("a/*\" ,"));
							add_text(jccs_pkg::CH_LF);
						end
						4: begin
							add_text(jccs_pkg::CH_SLASH);
							add_text(jccs_pkg::CH_STAR);
							repeat ($urandom_range(0, 5)) add_text(pick_from("a*/ \n,"));
							if ($urandom_range(0, 1) == 0)
								add_text(jccs_pkg::CH_STAR);
							add_text(jccs_pkg::CH_STAR);
							add_text(jccs_pkg::CH_SLASH);
						end
						5, 6: begin
							add_text(jccs_pkg::CH_COMMA);
							nws = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
								: $urandom_range(0, 4);
							repeat (nws) add_text(pick_from(" \t\n\r"));
							add_text(pick_from("]}a,/"));
						end
						7: repeat ($urandom_range(1, 3)) add_text(pick_from(" \t\n\r"));
						8: begin
							add_text(jccs_pkg::CH_SLASH);
							add_text(pick_from("a1 ]\""));
						end
						default: add_text(8'($urandom_range(0, 255)));
					endcase
				end
				// cut some texts short, inside a comment or string at times
				if ($urandom_range(0, 7) == 0) begin
					cut = $urandom_range(1, text_q.size());
					while (text_q.size() > cut) void'(text_q.pop_back());
				end
			end
			foreach (text_q[i])
				send_word(text_q[i], i == text_q.size() - 1);
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		clear_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_comments();
		test_strings();
		test_commas();
		test_text_end();
		test_ws_overflow();
		test_backpressure();
		test_random();
		repeat (40) @(posedge clk);
		if (clean_q.size() != 0) begin
			fails++;
			$display("%0t: %0d expected words never arrived", $realtime, clean_q.size());
		end
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/jccs_pkg.sv
src/jccs_queue.sv
src/jccs_front.sv
src/jccs_back.sv
src/json5_comment_comma_stripper.sv
verif/testbench.sv
